[src/mount_prefix_longest_match_defines.svh]
// assertion macros for the mount prefix matcher
`ifndef MOUNT_PREFIX_LONGEST_MATCH_DEFINES_SVH
`define MOUNT_PREFIX_LONGEST_MATCH_DEFINES_SVH

// same-cycle implication
`define MPLM_ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mplm same-cycle check failed");

// next-cycle implication
`define MPLM_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mplm next-cycle check failed");

`endif

[src/mplm_pkg.sv]
// shared types and constants of the mount prefix matcher
`default_nettype none

package mplm_pkg;

   localparam int TYPE_W     = 2;
   localparam int CH_W       = 8;
   localparam int HANDLE_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 3;
   localparam int STRIP_W    = 5;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_MOUNT = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_PATH  = 2'd2;

   localparam logic [CH_W-1:0] SLASH_CH = 8'h2F;
   localparam logic [CH_W-1:0] NUL_CH   = 8'h00;

   localparam logic KIND_MOUNT   = 1'b0;
   localparam logic KIND_RESOLVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOUNT,
      ST_SCAN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic clear;
      logic mount_do;
      logic scan_issue;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                  item_last;
      logic [TYPE_W-1:0]     item_type;
      logic                  rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

[src/mplm_ctrl.sv]
// controller state machine of the mount prefix matcher
`default_nettype none

module mplm_ctrl #(
   parameter int MAX_MOUNTS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [mplm_pkg::TYPE_W-1:0]       req_tuser,
   input  wire mplm_pkg::sts_type                 sts,
   output mplm_pkg::cmd_type                      cmd,
   output logic [(MAX_MOUNTS > 1 ? $clog2(MAX_MOUNTS) : 1)-1:0] scan_idx
);

   localparam int SW = (MAX_MOUNTS > 1) ? $clog2(MAX_MOUNTS) : 1;
   localparam int CW = $clog2(MAX_MOUNTS + 1);
   localparam logic [CW-1:0] CNT_END = CW'(MAX_MOUNTS);

   mplm_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mplm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      scan_idx   = cnt_ff[SW-1:0];
      unique case (state_ff)
         mplm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               priority if (req_tuser == mplm_pkg::REQ_CLEAR) begin
                  cmd.clear = 1'b1;
               end else if (req_tuser == mplm_pkg::REQ_MOUNT) begin
                  state_in = mplm_pkg::ST_MOUNT;
               end else if (req_tuser == mplm_pkg::REQ_PATH) begin
                  state_in = mplm_pkg::ST_SCAN;
                  cnt_in   = '0;
               end else begin
                  state_in = mplm_pkg::ST_IDLE;
               end
            end
         end
         mplm_pkg::ST_MOUNT: begin
            cmd.mount_do = 1'b1;
            state_in     = sts.item_last ? mplm_pkg::ST_DONE : mplm_pkg::ST_IDLE;
         end
         mplm_pkg::ST_SCAN: begin
            // issue reads for slots 0..n-1, last compare lands when count hits n
            if (cnt_ff != CNT_END) begin
               cmd.scan_issue = 1'b1;
               cnt_in         = cnt_ff + 1'b1;
            end else begin
               state_in = sts.item_last ? mplm_pkg::ST_DONE : mplm_pkg::ST_IDLE;
            end
         end
         mplm_pkg::ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = mplm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mplm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/mplm_datapath.sv]
// prefix table, match vector, selection and result register
`default_nettype none

module mplm_datapath #(
   parameter int MAX_MOUNTS = 8,
   parameter int MAX_PREFIX = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mplm_pkg::cmd_type                   cmd,
   input  wire logic [(MAX_MOUNTS > 1 ? $clog2(MAX_MOUNTS) : 1)-1:0] scan_idx,
   output mplm_pkg::sts_type                        sts,
   input  wire logic [mplm_pkg::TYPE_W-1:0]         req_type,
   input  wire logic [mplm_pkg::CH_W-1:0]           req_ch,
   input  wire logic                                req_last,
   input  wire logic [mplm_pkg::HANDLE_W-1:0]       req_handle,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [mplm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_kind
);

   localparam int SW    = (MAX_MOUNTS > 1) ? $clog2(MAX_MOUNTS) : 1;
   localparam int PW    = $clog2(MAX_PREFIX + 1);
   localparam int LW    = $clog2(MAX_PREFIX);
   localparam int DEPTH = MAX_MOUNTS * MAX_PREFIX;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [PW-1:0] POS_MAX  = PW'(MAX_PREFIX);
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_PREFIX - 1);
   localparam logic [AW-1:0] ROW      = AW'(MAX_PREFIX);

   // prefix character store
   logic [mplm_pkg::CH_W-1:0] mem [DEPTH];
   logic [mplm_pkg::CH_W-1:0] rd_data_ff;

   // per slot table
   logic [MAX_MOUNTS-1:0]         used_ff;
   logic [MAX_MOUNTS-1:0]         match_ff;
   logic [MAX_MOUNTS-1:0]         row_slash_ff;
   logic [LW-1:0]                 len_ff [MAX_MOUNTS];
   logic [mplm_pkg::HANDLE_W-1:0] handle_ff [MAX_MOUNTS];

   // string progress
   logic [PW-1:0] pos_ff, pos_in;
   logic          str_ended_ff, str_ended_in;
   logic          overflow_ff;
   logic [SW-1:0] fill_ff;
   logic          fill_ok_ff;

   // latched item
   logic [mplm_pkg::TYPE_W-1:0]   it_type_ff;
   logic [mplm_pkg::CH_W-1:0]     it_ch_ff;
   logic                          it_last_ff;
   logic [mplm_pkg::HANDLE_W-1:0] it_handle_ff;
   logic                          it_active_ff, it_active_in;
   logic [PW-1:0]                 p_cur_ff;

   // compare stage
   logic          cmp_valid_ff;
   logic [SW-1:0] cmp_slot_ff;

   // result holding
   logic                          res_kind_ff;
   logic [mplm_pkg::STATUS_W-1:0] res_status_ff;
   logic                          best_found_ff;
   logic [SW-1:0]                 best_slot_ff;
   logic [LW-1:0]                 best_len_ff;
   logic [mplm_pkg::HANDLE_W-1:0] best_handle_ff;
   logic                          best_root_ff;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mplm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_kind_ff;

   // first free slot
   logic [SW-1:0] free_idx;
   logic          free_ok;

   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = MAX_MOUNTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = SW'(i);
            free_ok  = 1'b1;
         end
      end
   end

   // accept side
   logic take_item;

   always_comb begin
      take_item    = cmd.accept && (req_type == mplm_pkg::REQ_MOUNT ||
                                    req_type == mplm_pkg::REQ_PATH);
      it_active_in = !str_ended_ff && (req_ch != mplm_pkg::NUL_CH);
      str_ended_in = str_ended_ff || (req_ch == mplm_pkg::NUL_CH);
      pos_in       = pos_ff;
      if (it_active_in && pos_ff != POS_MAX) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // mount step
   logic                          first_pick;
   logic                          n_zero;
   logic                          recompute;
   logic [SW-1:0]                 fill_now;
   logic                          fill_ok_now;
   logic                          ovf_now;
   logic                          wr_en;
   logic [mplm_pkg::STATUS_W-1:0] mount_status;
   logic                          commit;
   logic [AW-1:0]                 wr_addr;

   always_comb begin
      first_pick  = it_active_ff && (p_cur_ff == '0);
      n_zero      = (pos_ff == '0);
      recompute   = first_pick || (it_last_ff && n_zero);
      fill_now    = recompute ? free_idx : fill_ff;
      fill_ok_now = recompute ? free_ok : fill_ok_ff;
      ovf_now     = (first_pick ? 1'b0 : overflow_ff) ||
                    (it_active_ff && p_cur_ff >= POS_LAST);
      wr_en       = cmd.mount_do && it_active_ff && (p_cur_ff < POS_LAST) && fill_ok_now;
      priority if (!fill_ok_now) begin
         mount_status = mplm_pkg::STATUS_FULL;
      end else if (n_zero || ovf_now) begin
         mount_status = mplm_pkg::STATUS_BAD_LEN;
      end else begin
         mount_status = mplm_pkg::STATUS_OK;
      end
      commit  = cmd.mount_do && it_last_ff && (mount_status == mplm_pkg::STATUS_OK);
      wr_addr = AW'(fill_now) * ROW + AW'(p_cur_ff);
   end

   // scan read address, out-of-row positions never get compared
   logic [AW-1:0] rd_addr;

   always_comb begin
      rd_addr = AW'(scan_idx) * ROW;
      if (p_cur_ff < POS_MAX) begin
         rd_addr = AW'(scan_idx) * ROW + AW'(p_cur_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= it_ch_ff;
      end
      if (cmd.scan_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // compare stage for one slot
   logic [PW-1:0] cmp_len;
   logic          cmp_root;
   logic          cmp_mism;
   logic          cmp_new_match;
   logic          cmp_better;

   always_comb begin
      cmp_len  = PW'(len_ff[cmp_slot_ff]);
      cmp_root = (cmp_len == PW'(1)) && row_slash_ff[cmp_slot_ff];
      cmp_mism = 1'b0;
      if (p_cur_ff < cmp_len) begin
         cmp_mism = (rd_data_ff != it_ch_ff);
      end else if (p_cur_ff == cmp_len && !cmp_root) begin
         cmp_mism = (it_ch_ff != mplm_pkg::SLASH_CH);
      end
      cmp_new_match = match_ff[cmp_slot_ff] &&
                      !(it_active_ff && used_ff[cmp_slot_ff] && cmp_mism);
      cmp_better    = it_last_ff && used_ff[cmp_slot_ff] && cmp_new_match &&
                      (pos_ff >= cmp_len) && (cmp_len != '0) &&
                      (cmp_len > PW'(best_len_ff));
   end

   // result word
   logic [31:0] best_len_wide;
   logic [31:0] best_slot_wide;
   logic [mplm_pkg::STRIP_W-1:0] strip;
   logic        rel_root;

   always_comb begin
      best_len_wide  = 32'(best_len_ff);
      best_slot_wide = 32'(best_slot_ff);
      strip          = '0;
      rel_root       = 1'b0;
      if (best_found_ff && !best_root_ff) begin
         strip    = best_len_wide[mplm_pkg::STRIP_W-1:0];
         rel_root = (pos_ff == PW'(best_len_ff));
      end
      rsp_data_in = '0;
      rsp_data_in[1:0]   = res_status_ff;
      rsp_data_in[2]     = best_found_ff;
      if (best_found_ff) begin
         rsp_data_in[5:3]   = best_slot_wide[mplm_pkg::SLOT_W-1:0];
         rsp_data_in[13:6]  = best_handle_ff;
      end
      rsp_data_in[18:14] = strip;
      rsp_data_in[19]    = rel_root;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         match_ff     <= '1;
         pos_ff       <= '0;
         str_ended_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         fill_ff      <= '0;
         fill_ok_ff   <= 1'b1;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_MOUNTS; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cmp_valid_ff <= cmd.scan_issue;
         if (cmd.clear || cmd.finish) begin
            pos_ff       <= '0;
            str_ended_ff <= 1'b0;
            overflow_ff  <= 1'b0;
            match_ff     <= '1;
         end else if (take_item) begin
            pos_ff       <= pos_in;
            str_ended_ff <= str_ended_in;
         end
         if (cmd.clear) begin
            used_ff    <= '0;
            fill_ff    <= '0;
            fill_ok_ff <= 1'b1;
         end
         if (cmd.mount_do) begin
            fill_ff     <= fill_now;
            fill_ok_ff  <= fill_ok_now;
            overflow_ff <= ovf_now;
         end
         if (commit) begin
            used_ff[fill_now] <= 1'b1;
            len_ff[fill_now]  <= pos_ff[LW-1:0];
         end
         if (cmp_valid_ff) begin
            match_ff[cmp_slot_ff] <= cmp_new_match;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_item) begin
         it_type_ff     <= req_type;
         it_ch_ff       <= req_ch;
         it_last_ff     <= req_last;
         it_handle_ff   <= req_handle;
         it_active_ff   <= it_active_in;
         p_cur_ff       <= pos_ff;
         best_found_ff  <= 1'b0;
         best_len_ff    <= '0;
         res_kind_ff    <= (req_type == mplm_pkg::REQ_PATH) ? mplm_pkg::KIND_RESOLVE
                                                            : mplm_pkg::KIND_MOUNT;
         res_status_ff  <= mplm_pkg::STATUS_OK;
      end
      if (cmd.mount_do) begin
         res_status_ff <= mount_status;
      end
      if (wr_en && p_cur_ff == '0) begin
         row_slash_ff[fill_now] <= (it_ch_ff == mplm_pkg::SLASH_CH);
      end
      if (commit) begin
         handle_ff[fill_now] <= it_handle_ff;
      end
      cmp_slot_ff <= scan_idx;
      if (cmp_valid_ff && cmp_better) begin
         best_found_ff  <= 1'b1;
         best_slot_ff   <= cmp_slot_ff;
         best_len_ff    <= cmp_len[LW-1:0];
         best_handle_ff <= handle_ff[cmp_slot_ff];
         best_root_ff   <= cmp_root;
      end
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= res_kind_ff;
      end
   end

   assign sts.item_last = it_last_ff;
   assign sts.item_type = it_type_ff;
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_kind   = rsp_kind_ff;

endmodule

`default_nettype wire

[src/mount_prefix_longest_match.sv]
// mount prefix table with longest prefix match of streamed paths
// req channel: one character word per handshake, tuser selects clear, mount
//   character or path character, tlast marks the final character of a string
// rsp channel: one word per finished string (mount status or resolve result)
// handling per accepted word:
//   clear: empties the slot table and string progress, no result
//   mount character: stored in the chosen slot's row, the last one also ends in a status result
//   path character: each slot is compared in turn, one read of the character store
//     per cycle, and the last one also ends in a resolve result
//   rsp_tvalid comes from the output register, set when the done state hands off the result
// a finished result sits in the output register while the next word is taken;
//   only a second result waits for rsp_tready
// reset clears the slot table, match flags and string progress; the character
//   store and handles keep no reset and are only used for mounted slots
// rsp stall: rsp_tdata holds until rsp_tready, new strings still stream in
`default_nettype none

module mount_prefix_longest_match #(
   parameter int MAX_MOUNTS = 8,
   parameter int MAX_PREFIX = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input words
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [mplm_pkg::REQ_DATA_W-1:0]     req_tdata,  // ch[7:0], handle[15:8]
   input  wire logic [mplm_pkg::TYPE_W-1:0]         req_tuser,  // req_type[1:0]
   input  wire logic                                req_tlast,  // last
   // result words
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status[1:0], found[2], slot[5:3], out_handle[13:6], strip_count[18:14],
   // rel_is_root[19], zero[23:20]
   output logic [mplm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic [0:0]                               rsp_tuser   // kind[0]
);

   localparam int SW = (MAX_MOUNTS > 1) ? $clog2(MAX_MOUNTS) : 1;

   mplm_pkg::cmd_type cmd;
   mplm_pkg::sts_type sts;
   logic [SW-1:0]     scan_idx;
   logic              rsp_kind;

   // sequencer: item acceptance, slot scan count, result hand-off
   mplm_ctrl #(
      .MAX_MOUNTS (MAX_MOUNTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd),
      .scan_idx   (scan_idx)
   );

   // table, character store, per-slot compare and best-match tracking
   mplm_datapath #(
      .MAX_MOUNTS (MAX_MOUNTS),
      .MAX_PREFIX (MAX_PREFIX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .scan_idx   (scan_idx),
      .sts        (sts),
      .req_type   (req_tuser),
      .req_ch     (req_tdata[7:0]),
      .req_last   (req_tlast),
      .req_handle (req_tdata[15:8]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_kind   (rsp_kind)
   );

   assign rsp_tuser[0] = rsp_kind;

endmodule

`default_nettype wire

[src/mplm_checker.sv]
// port-level checks of the mount prefix matcher and their binding
`default_nettype none

`include "mount_prefix_longest_match_defines.svh"

module mplm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tlast};

   // a stalled result word holds
   `MPLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a character word closes the input in the cycle after it is taken
   `MPLM_ASSERT_NEXT(a_char_busy, clock, reset, req_tvalid && req_tready && (req_tuser == 2'd1 || req_tuser == 2'd2), !req_tready)

   // mount results carry only a legal status
   `MPLM_ASSERT_IMPLIES(a_mount_word, clock, reset, rsp_tvalid && rsp_tuser[0] == 1'b0, rsp_tdata[19:2] == 18'd0 && rsp_tdata[1:0] != 2'd3)

   // resolve results have zero status and empty fields when nothing matched
   `MPLM_ASSERT_IMPLIES(a_miss_word, clock, reset, rsp_tvalid && rsp_tuser[0] == 1'b1 && !rsp_tdata[2], rsp_tdata[19:0] == 20'd0)

endmodule

bind mount_prefix_longest_match mplm_checker u_mplm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
